@@ rtl/rrcf_pkg.sv @@
// Shared types, codes and the CRC-32 byte fold for the run record framer.
// No dependencies; imported by rrcf_out_stage and run_record_crc_framer_top.
`timescale 1ns / 1ps
`default_nettype none

package rrcf_pkg;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET   = 32'hFFFFFFFF;
  localparam logic [15:0] NO_RUN       = 16'hFFFF;
  localparam int unsigned TRAILER_LEN  = 6;
  localparam int unsigned BEAT_W       = $clog2(TRAILER_LEN);
  localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(TRAILER_LEN - 1);

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_TRAILER = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_RUN  = 2'd1,
    ST_IS_OPEN = 2'd2
  } status_e;

  // One pending result: a single word, or a six-word trailer.
  typedef struct packed {
    kind_e        kind;
    status_e      status;
    logic [15:0]  run;
    logic [31:0]  total;
    logic [47:0]  bytes;  // beat k takes bytes[8k+7:8k]
  } desc_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/run_record_crc_framer_top.sv @@
// Run record framer top: run state, CRC-32 fold, config registers and output stage.
// Depends on rrcf_pkg and rrcf_out_stage.
//
//  channel   dir  handshake                     content
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: data_byte; tuser: command
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_byte,status,run,total;
//                                               tuser: out_kind; tlast: last
//  cfg       in   cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// One input word per cycle; the run state and CRC update in the accepting cycle.
// Data, open and refused commands give one output word; a close gives six.
// An output register plus one skid entry buffer results; s_axis_tready drops
// only while the skid entry is occupied, e.g. during a stalled or playing trailer.
// Reset clears the run state, presets the CRC and empties the output stage.
`timescale 1ns / 1ps
`default_nettype none

module run_record_crc_framer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [7:0] out_byte, [9:8] status,
                                           // [25:10] run_number, [57:26] byte_total
  output logic [1:0]       m_axis_tuser,   // [1:0] out_kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i
);
  import rrcf_pkg::*;

  localparam logic CFG_MAGIC_HIGH = 1'b0;
  localparam logic CFG_MAGIC_LOW  = 1'b1;

  logic        run_open_q, run_open_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] count_q, count_d;
  logic [15:0] run_q, run_d;
  logic [7:0]  magic_high_q, magic_low_q;

  logic        accept, push, stage_ready;
  desc_t       desc;
  logic [31:0] crc_out;
  logic [31:0] count_inc;
  kind_e       out_kind;
  status_e     out_status;
  logic [7:0]  out_byte;
  logic [15:0] out_run;
  logic [31:0] out_total;

  assign s_axis_tready = stage_ready;
  assign accept        = s_axis_tvalid && stage_ready;
  assign crc_out       = crc_q ^ CRC_PRESET;
  assign count_inc     = count_q + 32'd1;

  always_comb begin
    run_open_d  = run_open_q;
    crc_d       = crc_q;
    count_d     = count_q;
    run_d       = run_q;
    push        = 1'b0;
    desc.kind   = KIND_STATUS;
    desc.status = ST_NO_RUN;
    desc.run    = NO_RUN;
    desc.total  = 32'd0;
    desc.bytes  = 48'd0;
    if (accept) begin
      unique case (cmd_e'(s_axis_tuser))
        CMD_DATA: begin
          push = 1'b1;
          if (run_open_q) begin
            count_d     = count_inc;
            crc_d       = crc_fold(crc_q, s_axis_tdata);
            desc.kind   = KIND_PAYLOAD;
            desc.status = ST_OK;
            desc.run    = run_q;
            desc.total  = count_inc;
            desc.bytes  = {40'd0, s_axis_tdata};
          end
        end
        CMD_OPEN: begin
          push     = 1'b1;
          desc.run = run_q;
          if (run_open_q) begin
            desc.status = ST_IS_OPEN;
            desc.total  = count_q;
          end else begin
            run_open_d  = 1'b1;
            count_d     = 32'd0;
            crc_d       = CRC_PRESET;
            desc.status = ST_OK;
          end
        end
        CMD_CLOSE: begin
          push = 1'b1;
          if (run_open_q) begin
            desc.kind   = KIND_TRAILER;
            desc.status = ST_OK;
            desc.run    = run_q;
            desc.total  = count_q;
            desc.bytes  = {crc_out, magic_low_q, magic_high_q};
            run_open_d  = 1'b0;
            count_d     = 32'd0;
            crc_d       = CRC_PRESET;
            run_d       = run_q + 16'd1;
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q   <= 1'b0;
      crc_q        <= CRC_PRESET;
      count_q      <= 32'd0;
      run_q        <= 16'd0;
      magic_high_q <= 8'd0;
      magic_low_q  <= 8'd0;
    end else begin
      run_open_q <= run_open_d;
      crc_q      <= crc_d;
      count_q    <= count_d;
      run_q      <= run_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAGIC_HIGH: magic_high_q <= cfg_wdata_i;
          CFG_MAGIC_LOW:  magic_low_q  <= cfg_wdata_i;
          default:        magic_low_q  <= magic_low_q;
        endcase
      end
    end
  end

  rrcf_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .desc_i   (desc),
    .ready_o  (stage_ready),
    .valid_o  (m_axis_tvalid),
    .take_i   (m_axis_tready),
    .kind_o   (out_kind),
    .byte_o   (out_byte),
    .status_o (out_status),
    .run_o    (out_run),
    .total_o  (out_total),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {6'd0, out_total, out_run, out_status, out_byte};

`ifndef SYNTH
  a_close_bumps_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == CMD_CLOSE && run_open_q) |=> (run_q == $past(run_q) + 16'd1))
    else $error("run number not advanced on close");

  a_closed_idle_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_open_q |-> (count_q == 32'd0)) else $error("byte count held without open run");

  a_refused_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == CMD_DATA && !run_open_q) |=> $stable(crc_q))
    else $error("CRC changed on refused data");
`endif

endmodule

`default_nettype wire

@@ rtl/rrcf_out_stage.sv @@
// Output register with one skid entry; plays out single words and six-word trailers.
// Depends on rrcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrcf_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rrcf_pkg::desc_t desc_i,
  output logic                ready_o,
  output logic                valid_o,
  input  wire logic           take_i,
  output rrcf_pkg::kind_e     kind_o,
  output logic [7:0]          byte_o,
  output rrcf_pkg::status_e   status_o,
  output logic [15:0]         run_o,
  output logic [31:0]         total_o,
  output logic                last_o
);
  import rrcf_pkg::*;

  desc_t              out_q, out_d, skid_q, skid_d;
  logic               out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic [BEAT_W-1:0]  beat_q, beat_d;
  logic               fire, last_beat, done;

  assign fire      = out_valid_q && take_i;
  assign last_beat = (out_q.kind != KIND_TRAILER) || (beat_q == BEAT_LAST);
  assign done      = fire && last_beat;
  assign ready_o   = !skid_valid_q;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    beat_d       = beat_q;
    if (done) begin
      beat_d = '0;
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = desc_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else begin
      if (fire) beat_d = beat_q + BEAT_W'(1);
      if (push_i) begin
        if (!out_valid_q) begin
          out_d       = desc_i;
          out_valid_d = 1'b1;
        end else begin
          skid_d       = desc_i;
          skid_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      beat_q       <= '0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      beat_q       <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  always_comb begin
    unique case (beat_q)
      3'd0:    byte_o = out_q.bytes[7:0];
      3'd1:    byte_o = out_q.bytes[15:8];
      3'd2:    byte_o = out_q.bytes[23:16];
      3'd3:    byte_o = out_q.bytes[31:24];
      3'd4:    byte_o = out_q.bytes[39:32];
      3'd5:    byte_o = out_q.bytes[47:40];
      default: byte_o = 8'd0;
    endcase
  end

  assign valid_o  = out_valid_q;
  assign kind_o   = out_q.kind;
  assign status_o = out_q.status;
  assign run_o    = out_q.run;
  assign total_o  = out_q.total;
  assign last_o   = last_beat;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid entry held without output word");

  a_beat_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q <= BEAT_LAST) else $error("trailer beat index out of range");

  a_beat_only_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && beat_q != '0) |-> (out_q.kind == KIND_TRAILER))
    else $error("beat advanced on a single-word result");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !done) |=> out_valid_q) else $error("pushed word lost");
`endif

endmodule

`default_nettype wire
